@@ rtl/utgcg_pkg.sv @@
// ----------------------------------------------------------------------------
// utgcg_pkg
// Shared types, constants, 5x7 font table and helpers for the text glyph
// column generator.
// ----------------------------------------------------------------------------
package utgcg_pkg;

  localparam int unsigned GLYPH_COUNT = 96;
  localparam int unsigned GLYPH_COLS  = 5;
  localparam int unsigned GLYPH_ROWS  = 7;

  localparam int unsigned CodeW  = 21;
  localparam int unsigned IdxW   = 7;
  localparam int unsigned ColW   = 3;
  localparam int unsigned CursW  = 16;
  localparam int unsigned RowW   = 12;
  localparam int unsigned AdvW   = 6;
  localparam int unsigned ColorW = 16;

  localparam logic [CodeW-1:0] CODE_SPACE    = CodeW'(32);
  localparam logic [CodeW-1:0] CODE_FIRST    = CodeW'(32);
  localparam logic [CodeW-1:0] CODE_LAST     = CodeW'(127);
  localparam logic [CodeW-1:0] CODE_QUESTION = CodeW'(63);

  localparam logic [7:0] LEAD2 = 8'hC0;
  localparam logic [7:0] LEAD3 = 8'hE0;
  localparam logic [7:0] LEAD4 = 8'hF0;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_LARGE_FONT   = 2'd0,
    CFG_TEXT_COLOR   = 2'd1,
    CFG_CHAR_ADVANCE = 2'd2
  } cfg_idx_e;

  typedef logic [0:GLYPH_COLS-1][GLYPH_ROWS-1:0] glyph_t;

  localparam glyph_t GLYPH_ROM [GLYPH_COUNT] = '{
    '{7'h00,7'h00,7'h00,7'h00,7'h00}, '{7'h00,7'h00,7'h5F,7'h00,7'h00},
    '{7'h00,7'h07,7'h00,7'h07,7'h00}, '{7'h14,7'h7F,7'h14,7'h7F,7'h14},
    '{7'h24,7'h2A,7'h7F,7'h2A,7'h12}, '{7'h23,7'h13,7'h08,7'h64,7'h62},
    '{7'h36,7'h49,7'h55,7'h22,7'h50}, '{7'h00,7'h05,7'h03,7'h00,7'h00},
    '{7'h00,7'h1C,7'h22,7'h41,7'h00}, '{7'h00,7'h41,7'h22,7'h1C,7'h00},
    '{7'h14,7'h08,7'h3E,7'h08,7'h14}, '{7'h08,7'h08,7'h3E,7'h08,7'h08},
    '{7'h00,7'h50,7'h30,7'h00,7'h00}, '{7'h08,7'h08,7'h08,7'h08,7'h08},
    '{7'h00,7'h60,7'h60,7'h00,7'h00}, '{7'h20,7'h10,7'h08,7'h04,7'h02},
    '{7'h3E,7'h51,7'h49,7'h45,7'h3E}, '{7'h00,7'h42,7'h7F,7'h40,7'h00},
    '{7'h42,7'h61,7'h51,7'h49,7'h46}, '{7'h21,7'h41,7'h45,7'h4B,7'h31},
    '{7'h18,7'h14,7'h12,7'h7F,7'h10}, '{7'h27,7'h45,7'h45,7'h45,7'h39},
    '{7'h3C,7'h4A,7'h49,7'h49,7'h30}, '{7'h01,7'h71,7'h09,7'h05,7'h03},
    '{7'h36,7'h49,7'h49,7'h49,7'h36}, '{7'h06,7'h49,7'h49,7'h29,7'h1E},
    '{7'h00,7'h36,7'h36,7'h00,7'h00}, '{7'h00,7'h56,7'h36,7'h00,7'h00},
    '{7'h08,7'h14,7'h22,7'h41,7'h00}, '{7'h14,7'h14,7'h14,7'h14,7'h14},
    '{7'h00,7'h41,7'h22,7'h14,7'h08}, '{7'h02,7'h01,7'h51,7'h09,7'h06},
    '{7'h32,7'h49,7'h79,7'h41,7'h3E}, '{7'h7E,7'h11,7'h11,7'h11,7'h7E},
    '{7'h7F,7'h49,7'h49,7'h49,7'h36}, '{7'h3E,7'h41,7'h41,7'h41,7'h22},
    '{7'h7F,7'h41,7'h41,7'h22,7'h1C}, '{7'h7F,7'h49,7'h49,7'h49,7'h41},
    '{7'h7F,7'h09,7'h09,7'h09,7'h01}, '{7'h3E,7'h41,7'h49,7'h49,7'h7A},
    '{7'h7F,7'h08,7'h08,7'h08,7'h7F}, '{7'h00,7'h41,7'h7F,7'h41,7'h00},
    '{7'h20,7'h40,7'h41,7'h3F,7'h01}, '{7'h7F,7'h08,7'h14,7'h22,7'h41},
    '{7'h7F,7'h40,7'h40,7'h40,7'h40}, '{7'h7F,7'h02,7'h0C,7'h02,7'h7F},
    '{7'h7F,7'h04,7'h08,7'h10,7'h7F}, '{7'h3E,7'h41,7'h41,7'h41,7'h3E},
    '{7'h7F,7'h09,7'h09,7'h09,7'h06}, '{7'h3E,7'h41,7'h51,7'h21,7'h5E},
    '{7'h7F,7'h09,7'h19,7'h29,7'h46}, '{7'h46,7'h49,7'h49,7'h49,7'h31},
    '{7'h01,7'h01,7'h7F,7'h01,7'h01}, '{7'h3F,7'h40,7'h40,7'h40,7'h3F},
    '{7'h1F,7'h20,7'h40,7'h20,7'h1F}, '{7'h3F,7'h40,7'h38,7'h40,7'h3F},
    '{7'h63,7'h14,7'h08,7'h14,7'h63}, '{7'h07,7'h08,7'h70,7'h08,7'h07},
    '{7'h61,7'h51,7'h49,7'h45,7'h43}, '{7'h00,7'h7F,7'h41,7'h41,7'h00},
    '{7'h02,7'h04,7'h08,7'h10,7'h20}, '{7'h00,7'h41,7'h41,7'h7F,7'h00},
    '{7'h04,7'h02,7'h01,7'h02,7'h04}, '{7'h40,7'h40,7'h40,7'h40,7'h40},
    '{7'h00,7'h01,7'h02,7'h04,7'h00}, '{7'h20,7'h54,7'h54,7'h54,7'h78},
    '{7'h7F,7'h48,7'h44,7'h44,7'h38}, '{7'h38,7'h44,7'h44,7'h44,7'h20},
    '{7'h38,7'h44,7'h44,7'h48,7'h7F}, '{7'h38,7'h54,7'h54,7'h54,7'h18},
    '{7'h08,7'h7E,7'h09,7'h01,7'h02}, '{7'h0C,7'h52,7'h52,7'h52,7'h3E},
    '{7'h7F,7'h08,7'h04,7'h04,7'h78}, '{7'h00,7'h44,7'h7D,7'h40,7'h00},
    '{7'h20,7'h40,7'h44,7'h3D,7'h00}, '{7'h7F,7'h10,7'h28,7'h44,7'h00},
    '{7'h00,7'h41,7'h7F,7'h40,7'h00}, '{7'h7C,7'h04,7'h18,7'h04,7'h78},
    '{7'h7C,7'h08,7'h04,7'h04,7'h78}, '{7'h38,7'h44,7'h44,7'h44,7'h38},
    '{7'h7C,7'h14,7'h14,7'h14,7'h08}, '{7'h08,7'h14,7'h14,7'h18,7'h7C},
    '{7'h7C,7'h08,7'h04,7'h04,7'h08}, '{7'h48,7'h54,7'h54,7'h54,7'h20},
    '{7'h04,7'h3F,7'h44,7'h40,7'h20}, '{7'h3C,7'h40,7'h40,7'h20,7'h7C},
    '{7'h1C,7'h20,7'h40,7'h20,7'h1C}, '{7'h3C,7'h40,7'h30,7'h40,7'h3C},
    '{7'h44,7'h28,7'h10,7'h28,7'h44}, '{7'h0C,7'h50,7'h50,7'h50,7'h3C},
    '{7'h44,7'h64,7'h54,7'h4C,7'h44}, '{7'h00,7'h08,7'h36,7'h41,7'h00},
    '{7'h00,7'h00,7'h7F,7'h00,7'h00}, '{7'h00,7'h41,7'h36,7'h08,7'h00},
    '{7'h08,7'h04,7'h08,7'h10,7'h08}, '{7'h00,7'h00,7'h00,7'h00,7'h00}
  };

  // font table index of a code, '?' for anything outside the printable range
  function automatic logic [IdxW-1:0] glyph_idx(input logic [CodeW-1:0] code);
    logic [CodeW-1:0] pick;
    pick = (code >= CODE_FIRST && code <= CODE_LAST) ? code : CODE_QUESTION;
    return IdxW'(pick - CODE_FIRST);
  endfunction

  // clamp a widened cursor sum at the top of the 16-bit signed range
  function automatic logic [CursW-1:0] sat_hi(input logic signed [CursW+1:0] v);
    logic signed [CursW+1:0] lim;
    lim = (CursW+2)'(32767);
    return (v > lim) ? CursW'(32767) : v[CursW-1:0];
  endfunction

endpackage

@@ rtl/utf8_text_glyph_column_generator.sv @@
// ----------------------------------------------------------------------------
// utf8_text_glyph_column_generator
// Lenient UTF-8 decoder feeding a 5x7 font column generator with a cursor.
// ----------------------------------------------------------------------------
// Usage: string bytes enter on the in_* channel (valid/stall), first_i on the
// opening byte loads the cursor from start_x_i/start_y_i, last_i on the final
// byte flushes a partial sequence. Each drawn glyph leaves as five column
// items on the out_* channel; end_of_run_o marks the last item of a byte.
// A byte can yield zero, five or ten items (cut-short code plus its own).
// Config writes (cfg_we_i, cfg_idx_i, cfg_data_i) take effect at once; the user
// must make them only while the block is idle; the block does not enforce this.
// Timing: a byte is decoded in its accept cycle into a glyph job register;
// its columns then pass from the job register to the output register. The
// column sweep drains one item per cycle while the output does not stall.
// The next byte is accepted in the cycle the last column of the current
// job moves to the output register.
// Reset clears the cursor, the pending sequence, the job and output valid,
// and loads the register defaults. A stall on the output holds the output
// register and the column sweep; input stall rises once the job is pending.
// ----------------------------------------------------------------------------
module utf8_text_glyph_column_generator (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // config port
  input  logic                              cfg_we_i,
  input  logic [1:0]                        cfg_idx_i,
  input  logic [utgcg_pkg::ColorW-1:0]      cfg_data_i,
  // byte channel
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [7:0]                        in_byte_i,
  input  logic                              first_i,
  input  logic signed [utgcg_pkg::RowW-1:0] start_x_i,
  input  logic signed [utgcg_pkg::RowW-1:0] start_y_i,
  input  logic                              last_i,
  // column channel
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [utgcg_pkg::CursW-1:0] col_x_o,
  output logic signed [utgcg_pkg::RowW-1:0] row_y_o,
  output logic [utgcg_pkg::GLYPH_ROWS-1:0]  pattern_o,
  output logic [1:0]                        pixel_size_o,
  output logic [utgcg_pkg::ColorW-1:0]      color_o,
  output logic                              end_of_run_o
);

  localparam int unsigned CodeW = utgcg_pkg::CodeW;
  localparam int unsigned IdxW  = utgcg_pkg::IdxW;
  localparam int unsigned ColW  = utgcg_pkg::ColW;
  localparam int unsigned CursW = utgcg_pkg::CursW;
  localparam int unsigned RowW  = utgcg_pkg::RowW;
  localparam int unsigned AdvW  = utgcg_pkg::AdvW;
  localparam logic [ColW-1:0] LastCol = ColW'(utgcg_pkg::GLYPH_COLS - 1);

  // config registers
  logic                          large_font_q;
  logic [utgcg_pkg::ColorW-1:0]  text_color_q;
  logic [AdvW-1:0]               char_advance_q;

  // decoder state
  logic [CursW-1:0] cursor_q, cursor_d;
  logic [RowW-1:0]  base_y_q, base_y_d;
  logic [1:0]       seq_q, seq_d;
  logic [CodeW-1:0] acc_q, acc_d;

  // glyph job
  logic             job_vld_q, job_vld_d;
  logic             job_two_q, job_two_d;
  logic [IdxW-1:0]  idx0_q, idx0_d, idx1_q, idx1_d;
  logic [CursW-1:0] x0_q, x0_d, x1_q, x1_d;
  logic [RowW-1:0]  job_y_q, job_y_d;
  logic [ColW-1:0]  col_q, col_d;
  logic             gsel_q, gsel_d;

  // output register
  logic                          out_vld_q, out_vld_d;
  logic [CursW-1:0]              out_x_q, out_x_d;
  logic [RowW-1:0]               out_y_q, out_y_d;
  logic [utgcg_pkg::GLYPH_ROWS-1:0] out_pat_q, out_pat_d;
  logic [1:0]                    out_px_q, out_px_d;
  logic [utgcg_pkg::ColorW-1:0]  out_color_q, out_color_d;
  logic                          out_end_q, out_end_d;

  logic in_acc, load_en, job_last;

  // decode signals
  logic [CursW-1:0] c0;
  logic [RowW-1:0]  y0;
  logic [1:0]       seq0, seqm, lead_seq;
  logic [CodeW-1:0] acc0, lead_code, code_a, code_b;
  logic             is_cont, is_lead, vld_a, vld_b, gly_a, gly_b;
  logic [CursW-1:0] sum1, sum2;

  // emit signals
  logic [IdxW-1:0]  cur_idx;
  logic [CursW-1:0] cur_x;
  logic [3:0]       col_ofs;
  utgcg_pkg::glyph_t cur_glyph;

  assign load_en  = !out_vld_q || !out_stall_i;
  assign job_last = (col_q == LastCol) && (gsel_q || !job_two_q);
  assign in_stall_o = job_vld_q && !(load_en && job_last);
  assign in_acc   = in_valid_i && !in_stall_o;

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      large_font_q   <= 1'b0;
      text_color_q   <= 16'hFFFF;
      char_advance_q <= AdvW'(6);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        utgcg_pkg::CFG_LARGE_FONT:   large_font_q   <= cfg_data_i[0];
        utgcg_pkg::CFG_TEXT_COLOR:   text_color_q   <= cfg_data_i;
        utgcg_pkg::CFG_CHAR_ADVANCE: char_advance_q <= cfg_data_i[AdvW-1:0];
        default: ;
      endcase
    end
  end

  // byte decode: up to two codes, a cut-short one (a) and the byte's own (b)
  always_comb begin
    c0   = first_i ? {{(CursW-RowW){start_x_i[RowW-1]}}, start_x_i} : cursor_q;
    y0   = first_i ? start_y_i : base_y_q;
    seq0 = first_i ? 2'd0 : seq_q;
    acc0 = first_i ? '0 : acc_q;

    is_cont = (in_byte_i[7:6] == 2'b10);
    is_lead = (in_byte_i >= utgcg_pkg::LEAD2);
    if (in_byte_i < utgcg_pkg::LEAD3) begin
      lead_code = {16'd0, in_byte_i[4:0]};
      lead_seq  = 2'd1;
    end else if (in_byte_i < utgcg_pkg::LEAD4) begin
      lead_code = {17'd0, in_byte_i[3:0]};
      lead_seq  = 2'd2;
    end else begin
      lead_code = {18'd0, in_byte_i[2:0]};
      lead_seq  = 2'd3;
    end

    vld_a  = (seq0 != 2'd0) && !is_cont;
    code_a = acc0;
    seqm   = seq0 - 2'd1;
    if ((seq0 != 2'd0) && is_cont) begin
      acc_d  = {acc0[CodeW-7:0], in_byte_i[5:0]};
      code_b = acc_d;
      vld_b  = (seqm == 2'd0) || last_i;
      seq_d  = vld_b ? 2'd0 : seqm;
    end else if (is_lead) begin
      acc_d  = lead_code;
      code_b = lead_code;
      vld_b  = last_i;
      seq_d  = last_i ? 2'd0 : lead_seq;
    end else begin
      acc_d  = acc0;
      code_b = {13'd0, in_byte_i};
      vld_b  = 1'b1;
      seq_d  = 2'd0;
    end

    gly_a = vld_a && (code_a != utgcg_pkg::CODE_SPACE);
    gly_b = vld_b && (code_b != utgcg_pkg::CODE_SPACE);

    // saturation is monotonic, so two clamped steps equal one clamped double step
    sum1 = utgcg_pkg::sat_hi($signed({{2{c0[CursW-1]}}, c0}) +
                             $signed({{(CursW+2-AdvW){1'b0}}, char_advance_q}));
    sum2 = utgcg_pkg::sat_hi($signed({{2{c0[CursW-1]}}, c0}) +
                             $signed({{(CursW+1-AdvW){1'b0}}, char_advance_q, 1'b0}));

    cursor_d = cursor_q;
    base_y_d = base_y_q;
    if (in_acc) begin
      base_y_d = y0;
      unique case ({vld_a, vld_b})
        2'b11:         cursor_d = sum2;
        2'b10, 2'b01:  cursor_d = sum1;
        default:       cursor_d = c0;
      endcase
    end

    // job slots, first glyph to draw in slot 0
    job_y_d = y0;
    if (gly_a) begin
      idx0_d = utgcg_pkg::glyph_idx(code_a);
      x0_d   = c0;
    end else begin
      idx0_d = utgcg_pkg::glyph_idx(code_b);
      x0_d   = vld_a ? sum1 : c0;
    end
    idx1_d    = utgcg_pkg::glyph_idx(code_b);
    x1_d      = sum1;
    job_two_d = gly_a && gly_b;
  end

  // column sweep and output register
  always_comb begin
    cur_idx   = gsel_q ? idx1_q : idx0_q;
    cur_x     = gsel_q ? x1_q : x0_q;
    cur_glyph = utgcg_pkg::GLYPH_ROM[cur_idx];
    col_ofs   = large_font_q ? {col_q, 1'b0} : {1'b0, col_q};

    out_x_d     = utgcg_pkg::sat_hi($signed({{2{cur_x[CursW-1]}}, cur_x}) +
                                    $signed({{(CursW-2){1'b0}}, col_ofs}));
    out_y_d     = job_y_q;
    out_pat_d   = cur_glyph[col_q];
    out_px_d    = large_font_q ? 2'd2 : 2'd1;
    out_color_d = text_color_q;
    out_end_d   = job_last;

    if (load_en) begin
      out_vld_d = job_vld_q;
    end else begin
      out_vld_d = out_vld_q;
    end

    job_vld_d = job_vld_q;
    col_d     = col_q;
    gsel_d    = gsel_q;
    if (job_vld_q && load_en) begin
      if (col_q == LastCol) begin
        col_d  = '0;
        gsel_d = 1'b1;
        if (job_last) begin
          job_vld_d = 1'b0;
        end
      end else begin
        col_d = col_q + ColW'(1);
      end
    end
    if (in_acc) begin
      job_vld_d = gly_a || gly_b;
      col_d     = '0;
      gsel_d    = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_q  <= '0;
      base_y_q  <= '0;
      seq_q     <= '0;
      acc_q     <= '0;
      job_vld_q <= 1'b0;
      col_q     <= '0;
      gsel_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      cursor_q  <= cursor_d;
      base_y_q  <= base_y_d;
      if (in_acc) begin
        seq_q <= seq_d;
        acc_q <= acc_d;
      end
      job_vld_q <= job_vld_d;
      col_q     <= col_d;
      gsel_q    <= gsel_d;
      out_vld_q <= out_vld_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      job_two_q <= job_two_d;
      idx0_q    <= idx0_d;
      idx1_q    <= idx1_d;
      x0_q      <= x0_d;
      x1_q      <= x1_d;
      job_y_q   <= job_y_d;
    end
    if (load_en && job_vld_q) begin
      out_x_q     <= out_x_d;
      out_y_q     <= out_y_d;
      out_pat_q   <= out_pat_d;
      out_px_q    <= out_px_d;
      out_color_q <= out_color_d;
      out_end_q   <= out_end_d;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign col_x_o      = out_x_q;
  assign row_y_o      = out_y_q;
  assign pattern_o    = out_pat_q;
  assign pixel_size_o = out_px_q;
  assign color_o      = out_color_q;
  assign end_of_run_o = out_end_q;

endmodule

@@ dv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Checks the UTF-8 text glyph column generator. Byte strings go in with
// random bursts and gaps while the column side stalls on a changing pattern.
// A scoreboard decodes every accepted byte, draws its glyph columns, and
// compares each column the block sends out, field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;

  localparam int IdleLimit  = 1000;
  localparam int MaxReports = 10;

  typedef struct packed {
    logic signed [15:0] col_x;
    logic signed [11:0] row_y;
    logic [6:0]         pattern;
    logic [1:0]         pixel_size;
    logic [15:0]        color;
    logic               end_of_run;
  } column_t;

  // 5x7 font, codes 32..127, one entry per column
  localparam bit [6:0] FONT [96][5] = '{
    '{'h00,'h00,'h00,'h00,'h00}, '{'h00,'h00,'h5F,'h00,'h00}, '{'h00,'h07,'h00,'h07,'h00},
    '{'h14,'h7F,'h14,'h7F,'h14}, '{'h24,'h2A,'h7F,'h2A,'h12}, '{'h23,'h13,'h08,'h64,'h62},
    '{'h36,'h49,'h55,'h22,'h50}, '{'h00,'h05,'h03,'h00,'h00}, '{'h00,'h1C,'h22,'h41,'h00},
    '{'h00,'h41,'h22,'h1C,'h00}, '{'h14,'h08,'h3E,'h08,'h14}, '{'h08,'h08,'h3E,'h08,'h08},
    '{'h00,'h50,'h30,'h00,'h00}, '{'h08,'h08,'h08,'h08,'h08}, '{'h00,'h60,'h60,'h00,'h00},
    '{'h20,'h10,'h08,'h04,'h02}, '{'h3E,'h51,'h49,'h45,'h3E}, '{'h00,'h42,'h7F,'h40,'h00},
    '{'h42,'h61,'h51,'h49,'h46}, '{'h21,'h41,'h45,'h4B,'h31}, '{'h18,'h14,'h12,'h7F,'h10},
    '{'h27,'h45,'h45,'h45,'h39}, '{'h3C,'h4A,'h49,'h49,'h30}, '{'h01,'h71,'h09,'h05,'h03},
    '{'h36,'h49,'h49,'h49,'h36}, '{'h06,'h49,'h49,'h29,'h1E}, '{'h00,'h36,'h36,'h00,'h00},
    '{'h00,'h56,'h36,'h00,'h00}, '{'h08,'h14,'h22,'h41,'h00}, '{'h14,'h14,'h14,'h14,'h14},
    '{'h00,'h41,'h22,'h14,'h08}, '{'h02,'h01,'h51,'h09,'h06}, '{'h32,'h49,'h79,'h41,'h3E},
    '{'h7E,'h11,'h11,'h11,'h7E}, '{'h7F,'h49,'h49,'h49,'h36}, '{'h3E,'h41,'h41,'h41,'h22},
    '{'h7F,'h41,'h41,'h22,'h1C}, '{'h7F,'h49,'h49,'h49,'h41}, '{'h7F,'h09,'h09,'h09,'h01},
    '{'h3E,'h41,'h49,'h49,'h7A}, '{'h7F,'h08,'h08,'h08,'h7F}, '{'h00,'h41,'h7F,'h41,'h00},
    '{'h20,'h40,'h41,'h3F,'h01}, '{'h7F,'h08,'h14,'h22,'h41}, '{'h7F,'h40,'h40,'h40,'h40},
    '{'h7F,'h02,'h0C,'h02,'h7F}, '{'h7F,'h04,'h08,'h10,'h7F}, '{'h3E,'h41,'h41,'h41,'h3E},
    '{'h7F,'h09,'h09,'h09,'h06}, '{'h3E,'h41,'h51,'h21,'h5E}, '{'h7F,'h09,'h19,'h29,'h46},
    '{'h46,'h49,'h49,'h49,'h31}, '{'h01,'h01,'h7F,'h01,'h01}, '{'h3F,'h40,'h40,'h40,'h3F},
    '{'h1F,'h20,'h40,'h20,'h1F}, '{'h3F,'h40,'h38,'h40,'h3F}, '{'h63,'h14,'h08,'h14,'h63},
    '{'h07,'h08,'h70,'h08,'h07}, '{'h61,'h51,'h49,'h45,'h43}, '{'h00,'h7F,'h41,'h41,'h00},
    '{'h02,'h04,'h08,'h10,'h20}, '{'h00,'h41,'h41,'h7F,'h00}, '{'h04,'h02,'h01,'h02,'h04},
    '{'h40,'h40,'h40,'h40,'h40}, '{'h00,'h01,'h02,'h04,'h00}, '{'h20,'h54,'h54,'h54,'h78},
    '{'h7F,'h48,'h44,'h44,'h38}, '{'h38,'h44,'h44,'h44,'h20}, '{'h38,'h44,'h44,'h48,'h7F},
    '{'h38,'h54,'h54,'h54,'h18}, '{'h08,'h7E,'h09,'h01,'h02}, '{'h0C,'h52,'h52,'h52,'h3E},
    '{'h7F,'h08,'h04,'h04,'h78}, '{'h00,'h44,'h7D,'h40,'h00}, '{'h20,'h40,'h44,'h3D,'h00},
    '{'h7F,'h10,'h28,'h44,'h00}, '{'h00,'h41,'h7F,'h40,'h00}, '{'h7C,'h04,'h18,'h04,'h78},
    '{'h7C,'h08,'h04,'h04,'h78}, '{'h38,'h44,'h44,'h44,'h38}, '{'h7C,'h14,'h14,'h14,'h08},
    '{'h08,'h14,'h14,'h18,'h7C}, '{'h7C,'h08,'h04,'h04,'h08}, '{'h48,'h54,'h54,'h54,'h20},
    '{'h04,'h3F,'h44,'h40,'h20}, '{'h3C,'h40,'h40,'h20,'h7C}, '{'h1C,'h20,'h40,'h20,'h1C},
    '{'h3C,'h40,'h30,'h40,'h3C}, '{'h44,'h28,'h10,'h28,'h44}, '{'h0C,'h50,'h50,'h50,'h3C},
    '{'h44,'h64,'h54,'h4C,'h44}, '{'h00,'h08,'h36,'h41,'h00}, '{'h00,'h00,'h7F,'h00,'h00},
    '{'h00,'h41,'h36,'h08,'h00}, '{'h08,'h04,'h08,'h10,'h08}, '{'h00,'h00,'h00,'h00,'h00}
  };

  class glyph_scoreboard;
    column_t   cols_due[$];
    column_t   byte_cols[$];
    bit        large_font;
    bit [15:0] text_color;
    bit [5:0]  char_advance;
    int        cursor_x;
    int        base_y;
    int        seq_left;
    bit [20:0] code_acc;
    int        bytes_noted;
    int        cols_checked;
    int        mismatches;
    int        cut_short;
    int        edge_cols;

    function new();
      large_font   = 1'b0;
      text_color   = 16'hFFFF;
      char_advance = 6'd6;
      cursor_x     = 0;
      base_y       = 0;
      seq_left     = 0;
      code_acc     = '0;
      bytes_noted  = 0;
      cols_checked = 0;
      mismatches   = 0;
      cut_short    = 0;
      edge_cols    = 0;
    endfunction

    function void set_reg(utgcg_pkg::cfg_idx_e idx, bit [15:0] data);
      case (idx)
        utgcg_pkg::CFG_LARGE_FONT:   large_font   = data[0];
        utgcg_pkg::CFG_TEXT_COLOR:   text_color   = data;
        utgcg_pkg::CFG_CHAR_ADVANCE: char_advance = data[5:0];
        default: ;
      endcase
    endfunction

    function int clamp_x(int v);
      return (v > 32767) ? 32767 : v;
    endfunction

    // a space only moves the cursor
    function void draw_code(bit [20:0] code);
      int      pick;
      int      scale;
      column_t c;
      if (code == 21'd32) begin
        cursor_x = clamp_x(cursor_x + int'(char_advance));
        return;
      end
      pick  = (code >= 21'd32 && code <= 21'd127) ? int'(code) : 63;
      scale = large_font ? 2 : 1;
      for (int col = 0; col < 5; col++) begin
        c.col_x      = 16'(clamp_x(cursor_x + col * scale));
        c.row_y      = 12'(base_y);
        c.pattern    = FONT[pick - 32][col];
        c.pixel_size = 2'(scale);
        c.color      = text_color;
        c.end_of_run = 1'b0;
        if (c.col_x == 16'sd32767) edge_cols++;
        byte_cols.push_back(c);
      end
      cursor_x = clamp_x(cursor_x + int'(char_advance));
    endfunction

    function void note_byte(bit [7:0] b, bit is_first, bit signed [11:0] sx,
                            bit signed [11:0] sy, bit is_last);
      column_t c;
      bytes_noted++;
      byte_cols.delete();
      if (is_first) begin
        cursor_x = int'(sx);
        base_y   = int'(sy);
        seq_left = 0;
        code_acc = '0;
      end
      if (seq_left != 0 && b[7:6] == 2'b10) begin
        code_acc = {code_acc[14:0], b[5:0]};
        seq_left--;
        if (seq_left == 0 || is_last) begin
          seq_left = 0;
          draw_code(code_acc);
        end
      end else begin
        // a non-continuation flushes what was gathered, then starts a new sequence or stands alone
        if (seq_left != 0) begin
          seq_left = 0;
          cut_short++;
          draw_code(code_acc);
        end
        if (b >= 8'hC0) begin
          if (b < 8'hE0) begin
            code_acc = 21'(b & 8'h1F);
            seq_left = 1;
          end else if (b < 8'hF0) begin
            code_acc = 21'(b & 8'h0F);
            seq_left = 2;
          end else begin
            code_acc = 21'(b & 8'h07);
            seq_left = 3;
          end
          if (is_last) begin
            seq_left = 0;
            draw_code(code_acc);
          end
        end else begin
          draw_code(21'(b));
        end
      end
      if (byte_cols.size() > 0) begin
        c = byte_cols.pop_back();
        c.end_of_run = 1'b1;
        byte_cols.push_back(c);
      end
      foreach (byte_cols[i]) cols_due.push_back(byte_cols[i]);
    endfunction

    function void check_column(column_t got);
      column_t want;
      if (cols_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports) begin
          $display("ERROR: unexpected column x=%0d y=%0d pattern=%h end=%b",
                   got.col_x, got.row_y, got.pattern, got.end_of_run);
        end
        return;
      end
      want = cols_due.pop_front();
      cols_checked++;
      if (got.col_x !== want.col_x || got.row_y !== want.row_y ||
          got.pattern !== want.pattern || got.pixel_size !== want.pixel_size ||
          got.color !== want.color || got.end_of_run !== want.end_of_run) begin
        mismatches++;
        if (mismatches <= MaxReports) begin
          $display("ERROR: column %0d expected x=%0d y=%0d pat=%h size=%0d color=%h end=%b",
                   cols_checked, want.col_x, want.row_y, want.pattern, want.pixel_size,
                   want.color, want.end_of_run);
          $display("       actual   x=%0d y=%0d pat=%h size=%0d color=%h end=%b",
                   got.col_x, got.row_y, got.pattern, got.pixel_size, got.color,
                   got.end_of_run);
        end
      end
    endfunction

    function int pending();
      return cols_due.size();
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [1:0]         cfg_idx_i;
  logic [15:0]        cfg_data_i;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [7:0]         in_byte_i;
  logic               first_i;
  logic signed [11:0] start_x_i;
  logic signed [11:0] start_y_i;
  logic               last_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic signed [15:0] col_x_o;
  logic signed [11:0] row_y_o;
  logic [6:0]         pattern_o;
  logic [1:0]         pixel_size_o;
  logic [15:0]        color_o;
  logic               end_of_run_o;

  glyph_scoreboard sb;
  int burst_left;
  int strings_sent;
  int cycle_cnt;
  int stall_mode;
  int stall_left;
  int idle_cycles;

  utf8_text_glyph_column_generator dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_byte_i    (in_byte_i),
    .first_i      (first_i),
    .start_x_i    (start_x_i),
    .start_y_i    (start_y_i),
    .last_i       (last_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .col_x_o      (col_x_o),
    .row_y_o      (row_y_o),
    .pattern_o    (pattern_o),
    .pixel_size_o (pixel_size_o),
    .color_o      (color_o),
    .end_of_run_o (end_of_run_o)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // column side: stall pattern, checking, idle count for the watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 4);
      stall_left <= $urandom_range(40, 160);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      1:       out_stall_i <= ($urandom_range(0, 2) == 0);
      2:       out_stall_i <= ((cycle_cnt % 5) < 2);
      3:       out_stall_i <= ($urandom_range(0, 3) != 0);
      4:       out_stall_i <= ((cycle_cnt % 32) < 14);
      default: out_stall_i <= 1'b0;
    endcase
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_column('{col_x_o, row_y_o, pattern_o, pixel_size_o, color_o, end_of_run_o});
    end
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : watchdog
    while (idle_cycles < IdleLimit) @(posedge clk_i);
    $display("ERROR: no item moved for %0d cycles", IdleLimit);
    $display("TEST FAILED");
    $finish;
  end

  function automatic logic signed [11:0] rand_coord();
    if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? 12'sh7FF : 12'sh800;
    return 12'($urandom);
  endfunction

  task automatic send_item(input logic [7:0] b, input logic is_first,
                           input logic signed [11:0] sx, input logic signed [11:0] sy,
                           input logic is_last);
    int gap;
    bit hold;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      hold       = ($urandom_range(0, 39) == 0);
      burst_left = $urandom_range(1, 12);
      if (hold && gap == 0) gap = 1;
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
        // now and then let every column drain before going on
        if (hold) begin
          while (sb.pending() != 0) @(posedge clk_i);
        end
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_byte_i  <= b;
    first_i    <= is_first;
    start_x_i  <= sx;
    start_y_i  <= sy;
    last_i     <= is_last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_byte(b, is_first, sx, sy, is_last);
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_item(b, 1'b0, rand_coord(), rand_coord(), 1'b0);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(posedge clk_i);
    // a lead byte or a space leaves no column behind it
    repeat (6) @(posedge clk_i);
  endtask

  task automatic apply_settings(input logic lf, input logic [15:0] color,
                                input logic [5:0] adv);
    logic [15:0]         data [3];
    utgcg_pkg::cfg_idx_e regs [3];
    regs[0] = utgcg_pkg::CFG_LARGE_FONT;
    regs[1] = utgcg_pkg::CFG_TEXT_COLOR;
    regs[2] = utgcg_pkg::CFG_CHAR_ADVANCE;
    // upper data bits carry junk that the block must drop
    data[0] = {15'($urandom), lf};
    data[1] = color;
    data[2] = {10'($urandom), adv};
    for (int k = 0; k < 3; k++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= regs[k];
      cfg_data_i <= data[k];
      @(posedge clk_i);
      sb.set_reg(regs[k], data[k]);
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_string(input int n_chars, input bit with_first);
    logic [7:0] str_bytes[$];
    int         kind;
    int         code;
    int         len;
    int         n_cont;
    for (int i = 0; i < n_chars; i++) begin
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
        str_bytes.push_back(8'($urandom_range(33, 126)));
      end else if (kind < 50) begin
        str_bytes.push_back(8'h20);
      end else if (kind < 58) begin
        // overlong forms of printable codes
        code = $urandom_range(32, 127);
        if ($urandom_range(0, 1)) begin
          str_bytes.push_back(8'hC0 | 8'(code >> 6));
        end else begin
          str_bytes.push_back(8'hE0);
          str_bytes.push_back(8'h80 | 8'(code >> 6));
        end
        str_bytes.push_back(8'h80 | 8'(code & 63));
      end else if (kind < 82) begin
        // multi-byte sequence, complete or cut short
        len    = $urandom_range(2, 4);
        n_cont = (kind < 74) ? len - 1 : $urandom_range(0, len - 2);
        case (len)
          2:       str_bytes.push_back(8'hC0 | 8'($urandom_range(0, 31)));
          3:       str_bytes.push_back(8'hE0 | 8'($urandom_range(0, 15)));
          default: str_bytes.push_back(8'hF0 | 8'($urandom_range(0, 15)));
        endcase
        repeat (n_cont) str_bytes.push_back(8'h80 | 8'($urandom_range(0, 63)));
      end else if (kind < 88) begin
        str_bytes.push_back(8'($urandom_range(128, 191)));
      end else if (kind < 91) begin
        str_bytes.push_back($urandom_range(0, 1) ? 8'h00 : 8'h7F);
      end else begin
        str_bytes.push_back(8'($urandom));
      end
    end
    strings_sent++;
    foreach (str_bytes[i]) begin
      send_item(str_bytes[i], (i == 0 && with_first) || ($urandom_range(0, 29) == 0),
                rand_coord(), rand_coord(),
                (i == str_bytes.size() - 1) || ($urandom_range(0, 19) == 0));
    end
  endtask

  task automatic random_phase(input logic lf, input logic [15:0] color,
                              input logic [5:0] adv, input int n_bytes);
    int target;
    wait_idle();
    apply_settings(lf, color, adv);
    target = sb.bytes_noted + n_bytes;
    while (sb.bytes_noted < target) begin
      send_string($urandom_range(1, 10), $urandom_range(0, 5) != 0);
    end
  endtask

  initial begin
    sb          = new();
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = utgcg_pkg::CFG_LARGE_FONT;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    in_byte_i   = '0;
    first_i     = 1'b0;
    start_x_i   = '0;
    start_y_i   = '0;
    last_i      = 1'b0;
    burst_left  = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed, with the reset settings
    send_item(8'h41, 1'b1, 12'sh800, 12'sh800, 1'b0);
    send_byte(8'h20);
    send_byte(8'h7F);                          // blank glyph
    send_byte(8'h80);                          // stray continuation
    send_byte(8'hC3); send_byte(8'hA9);
    send_byte(8'hE2); send_byte(8'h82); send_byte(8'hAC);
    send_byte(8'hF0); send_byte(8'h9F); send_byte(8'h98); send_byte(8'h80);
    send_byte(8'hC1); send_byte(8'h42);        // lead cut short by a plain byte
    send_byte(8'hE5); send_byte(8'h00);        // zero byte cuts the sequence short
    send_byte(8'hFB); send_byte(8'h80); send_byte(8'h80); send_byte(8'h80);
    send_byte(8'hC0); send_byte(8'hA0);        // overlong space
    send_byte(8'hD0);                          // pending lead dropped by a new string
    send_item(8'h5A, 1'b1, 12'sh7FF, 12'sh7FF, 1'b0);
    send_byte(8'hE1);
    send_item(8'h80, 1'b0, rand_coord(), rand_coord(), 1'b1);
    send_item(8'hFF, 1'b0, rand_coord(), rand_coord(), 1'b1);

    random_phase(1'b0, 16'($urandom), 6'd6, 60);
    random_phase(1'b1, 16'($urandom), 6'd32, 60);
    random_phase(1'b0, 16'h0000, 6'd1, 60);
    random_phase(1'b1, 16'hFFFF, 6'd0, 60);
    random_phase(1'b0, 16'($urandom), 6'd63, 60);
    random_phase(1'b1, 16'($urandom), 6'($urandom_range(1, 32)), 60);

    wait_idle();
    repeat (20) @(posedge clk_i);
    $display("covered %0d bytes in %0d random strings plus directed cases, %0d columns checked",
             sb.bytes_noted, strings_sent, sb.cols_checked);
    $display("%0d sequences cut short, %0d columns at the cursor limit, %0d mismatches",
             sb.cut_short, sb.edge_cols, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
